FILE: hw/rtl/bounded_deque_with_search_delete_unit_macros.svh
// Assertion macros used by the deque top-level RTL file.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DELETE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DELETE_UNIT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define BDQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("deque check failed: invariant");

// The consequent holds in the same cycle as the antecedent.
`define BDQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed: next-cycle implication");

`endif

FILE: hw/rtl/bdqsd_pkg.sv
// Package with the beat types, codes and defaults of the deque block.
package bdqsd_pkg;

  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_SEARCH     = 3'd6,
    OP_DELETE     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] result_value;
    logic               last;
  } out_item_t;

endpackage

FILE: hw/rtl/bdqsd_ram.sv
// Entry store: one write port and one read port with registered read data.
module bdqsd_ram
  import bdqsd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/bounded_deque_with_search_delete_unit.sv
// Top level of the bounded deque with search and delete by value.
//
// The block keeps up to DEPTH signed 32-bit entries in a ring store with a
// front pointer and an entry count. An input beat (in_item: opcode, value)
// is taken when in_valid is high and in_stall is low; in_stall is high
// while an item is being worked on, so one item is in flight at a time.
// Every item yields one or more result beats on out_item, taken when
// out_valid is high and out_stall is low; the last beat of an item has
// last set. Only a list of a non-empty store gives more than one beat.
// A push, a clear or any request on an empty deque needs no read of the
// store; a pop reads one entry, a list reads every entry in turn, a
// search visits entries from the front until it finds a match or reaches
// the last, and a delete also moves each later entry up to close the gap.
// The final result beat turns valid in the cycle the block is ready again.
// Each visited entry uses the store's single read port, whose data is
// registered, and the shared slot adder and comparator for its compare or copy.
// A stalled receiver holds the result register; the block still accepts
// a new item while a result waits, and waits itself before emitting.
// Synchronous reset empties the deque and drops any pending result; the
// store contents are not cleared and are only read once written.
`include "bounded_deque_with_search_delete_unit_macros.svh"

module bounded_deque_with_search_delete_unit
  import bdqsd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_SH_RD,
    S_SH_WR,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  opcode_t            op_r, op_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [IW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [31:0]        res_value_r, res_value_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_rdata_unused_guard;
  logic [31:0]        ram_rdata;

  // Shared slot unit: ring position of logical index slot_k.
  logic [IW-1:0]      slot_k;
  logic [IW:0]        slot_sum;
  logic [IW-1:0]      slot_addr;
  logic [IW-1:0]      front_dec;
  logic [IW-1:0]      front_inc;
  logic [CW-1:0]      count_m1;
  logic [CW-1:0]      k_p1;
  logic [CW-1:0]      k_p2;
  logic               is_full;
  logic               is_empty;
  logic               k_is_last;
  logic               key_hit;
  logic               out_free;

  assign slot_sum  = {1'b0, front_r} + {1'b0, slot_k};
  assign slot_addr = (slot_sum >= DEPTH_W) ? IW'(slot_sum - DEPTH_W) : slot_sum[IW-1:0];
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;
  assign front_inc = (front_r == LAST_SLOT) ? '0 : front_r + 1'b1;
  assign count_m1  = count_r - 1'b1;
  assign k_p1      = k_r + 1'b1;
  assign k_p2      = k_r + CW'(2);
  assign is_full   = (count_r == DEPTH_C);
  assign is_empty  = (count_r == '0);
  assign k_is_last = (k_p1 == count_r);
  assign key_hit   = (ram_rdata == key_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Index fed to the slot unit depends on which step is running.
  always_comb begin
    case (state_r)
      S_IDLE: begin
        case (in_item.opcode)
          OP_PUSH_BACK: slot_k = count_r[IW-1:0];
          OP_POP_BACK:  slot_k = count_m1[IW-1:0];
          default:      slot_k = '0;
        endcase
      end
      S_SH_RD: slot_k = k_p1[IW-1:0];
      default: slot_k = k_r[IW-1:0];
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    k_nxt          = k_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_waddr      = slot_addr;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_item.opcode;
          key_nxt        = in_item.value;
          k_nxt          = '0;
          res_status_nxt = ST_OK;
          res_value_nxt  = '0;
          case (in_item.opcode)
            OP_PUSH_FRONT: begin
              state_nxt = S_EMIT;
              if (is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                ram_wdata = in_item.value;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              state_nxt = S_EMIT;
              if (is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = in_item.value;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_CLEAR: begin
              state_nxt = S_EMIT;
              count_nxt = '0;
              front_nxt = '0;
            end
            default: begin
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_EMIT;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_CHK;
              end
            end
          endcase
        end
      end

      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_CHK;
      end

      S_CHK: begin
        case (op_r)
          OP_POP_FRONT: begin
            res_value_nxt = ram_rdata;
            front_nxt     = front_inc;
            count_nxt     = count_m1;
            state_nxt     = S_EMIT;
          end
          OP_POP_BACK: begin
            res_value_nxt = ram_rdata;
            count_nxt     = count_m1;
            state_nxt     = S_EMIT;
          end
          OP_LIST: begin
            if (out_free) begin
              out_nxt.status       = ST_OK;
              out_nxt.result_value = ram_rdata;
              out_nxt.last         = k_is_last;
              out_valid_nxt        = 1'b1;
              if (k_is_last) begin
                state_nxt = S_IDLE;
              end else begin
                k_nxt     = k_p1;
                state_nxt = S_RD;
              end
            end
          end
          OP_SEARCH, OP_DELETE: begin
            if (key_hit) begin
              res_value_nxt = ram_rdata;
              if (op_r == OP_SEARCH) begin
                state_nxt = S_EMIT;
              end else if (k_is_last) begin
                count_nxt = count_m1;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_SH_RD;
              end
            end else if (k_is_last) begin
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_EMIT;
            end else begin
              k_nxt     = k_p1;
              state_nxt = S_RD;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SH_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SH_WR;
      end

      S_SH_WR: begin
        // Entry k+1 was read last cycle; it moves down into slot k.
        ram_we = 1'b1;
        k_nxt  = k_p1;
        if (k_p2 == count_r) begin
          count_nxt = count_m1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SH_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_nxt.status       = res_status_r;
          out_nxt.result_value = res_value_r;
          out_nxt.last         = 1'b1;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    k_r          <= k_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_r        <= out_nxt;
  end

  assign ram_rdata_unused_guard = slot_addr;

  bdqsd_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_rdata_unused_guard),
    .rdata (ram_rdata)
  );

  `BDQ_ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_C)
  `BDQ_ASSERT_ALWAYS(a_front_bound, front_r <= LAST_SLOT)
  `BDQ_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE)
  `BDQ_ASSERT_IMP(a_error_zero, out_valid_r && out_r.status != ST_OK, out_r.result_value == '0)
  `BDQ_ASSERT_IMP(a_multi_only_list, out_valid_r && !out_r.last, op_r == OP_LIST)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the bounded deque with search and delete by value.
`timescale 1ns / 100ps

module testbench;
  import bdqsd_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // The receiver's long hold-off, in cycles. The watchdog limit must stay well
  // above it, because no beat moves on either side while it lasts.
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;

  // A full list gives one beat per entry, so this tail is ample for any
  // straggling beat after the last expected one has arrived.
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;

  // One row of the directed table. A row with typed set carries the single
  // result that can be read straight off the behavior; the other rows are
  // checked against the shadow deque. A row with reps above one is issued
  // that many times, with the value stepping up by one each time.
  typedef struct packed {
    opcode_t     op;
    logic [31:0] value;
    logic [4:0]  reps;
    logic        typed;
    status_t     status;
    logic [31:0] result;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 19;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Every removal, lookup and the list on an empty deque after reset.
    '{OP_POP_FRONT,  32'd0,          5'd1,  1'b1, ST_EMPTY,     32'd0},
    '{OP_POP_BACK,   32'd0,          5'd1,  1'b1, ST_EMPTY,     32'd0},
    '{OP_LIST,       32'd0,          5'd1,  1'b1, ST_EMPTY,     32'd0},
    '{OP_SEARCH,     32'd7,          5'd1,  1'b1, ST_EMPTY,     32'd0},
    '{OP_DELETE,     32'd7,          5'd1,  1'b1, ST_EMPTY,     32'd0},
    // Clearing an already empty deque still answers ok.
    '{OP_CLEAR,      32'd0,          5'd1,  1'b1, ST_OK,        32'd0},
    // Extremes of the value field; the push at the front wraps the ring.
    '{OP_PUSH_FRONT, 32'h8000_0000,  5'd1,  1'b1, ST_OK,        32'd0},
    '{OP_PUSH_BACK,  32'h7fff_ffff,  5'd1,  1'b1, ST_OK,        32'd0},
    '{OP_SEARCH,     32'h7fff_ffff,  5'd1,  1'b1, ST_OK,        32'h7fff_ffff},
    '{OP_DELETE,     32'd3,          5'd1,  1'b1, ST_NOT_FOUND, 32'd0},
    // Fill up to DEPTH entries with -1, 0, 1 and so on.
    '{OP_PUSH_BACK,  32'hffff_ffff,  5'd14, 1'b0, ST_OK,        32'd0},
    // Inserts into a full deque are dropped at both ends.
    '{OP_PUSH_FRONT, 32'd1,          5'd1,  1'b1, ST_FULL,      32'd0},
    '{OP_PUSH_BACK,  32'd1,          5'd1,  1'b1, ST_FULL,      32'd0},
    // A list of a full deque, then a delete from the middle that closes a gap.
    '{OP_LIST,       32'd0,          5'd1,  1'b0, ST_OK,        32'd0},
    '{OP_DELETE,     32'd5,          5'd1,  1'b0, ST_OK,        32'd0},
    '{OP_POP_BACK,   32'd0,          5'd1,  1'b0, ST_OK,        32'd0},
    '{OP_POP_FRONT,  32'd0,          5'd1,  1'b1, ST_OK,        32'h8000_0000},
    '{OP_CLEAR,      32'd0,          5'd1,  1'b1, ST_OK,        32'd0},
    '{OP_LIST,       32'd0,          5'd1,  1'b1, ST_EMPTY,     32'd0}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Shadow copy of the deque, front at index 0, and the beats still owed.
  logic signed [31:0] shadow_deque[$];
  out_item_t          step_beats[$];
  out_item_t          owed_beats[$];

  // Both sides idle at random unless quiet is set. The sender raises
  // hold_req to ask the receiver for its long hold-off; the receiver drops
  // it once the hold-off is over.
  bit quiet;
  bit hold_req;

  int stuck_cycles;
  int mismatches;
  int beats_checked;
  int items_sent;
  int full_drops;
  int not_found_hits;
  int empty_hits;
  int longest_list;

  bounded_deque_with_search_delete_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t make_beat(status_t st, logic signed [31:0] v, logic lst);
    out_item_t b;
    b.status       = st;
    b.result_value = v;
    b.last         = lst;
    return b;
  endfunction

  // Applies one accepted item to the shadow deque and leaves the result beats
  // it causes in step_beats, in the order the block must send them.
  function automatic void deque_step(in_item_t it);
    int                 pos;
    int                 k;
    logic signed [31:0] v;
    step_beats.delete();
    pos = -1;
    case (it.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_deque.size() >= DEPTH) begin
          step_beats.push_back(make_beat(ST_FULL, '0, 1'b1));
        end else begin
          if (it.opcode == OP_PUSH_FRONT) shadow_deque.push_front(it.value);
          else shadow_deque.push_back(it.value);
          step_beats.push_back(make_beat(ST_OK, '0, 1'b1));
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_deque.size() == 0) begin
          step_beats.push_back(make_beat(ST_EMPTY, '0, 1'b1));
        end else begin
          if (it.opcode == OP_POP_FRONT) v = shadow_deque.pop_front();
          else v = shadow_deque.pop_back();
          step_beats.push_back(make_beat(ST_OK, v, 1'b1));
        end
      end
      OP_LIST: begin
        if (shadow_deque.size() == 0) begin
          step_beats.push_back(make_beat(ST_EMPTY, '0, 1'b1));
        end else begin
          for (k = 0; k < shadow_deque.size(); k++)
            step_beats.push_back(make_beat(ST_OK, shadow_deque[k],
                                           k == shadow_deque.size() - 1));
          if (shadow_deque.size() > longest_list) longest_list = shadow_deque.size();
        end
      end
      OP_CLEAR: begin
        shadow_deque.delete();
        step_beats.push_back(make_beat(ST_OK, '0, 1'b1));
      end
      default: begin
        // Search and delete both look for the first match from the front.
        if (shadow_deque.size() == 0) begin
          step_beats.push_back(make_beat(ST_EMPTY, '0, 1'b1));
        end else begin
          for (k = 0; k < shadow_deque.size(); k++)
            if (pos < 0 && shadow_deque[k] == it.value) pos = k;
          if (pos < 0) begin
            step_beats.push_back(make_beat(ST_NOT_FOUND, '0, 1'b1));
          end else begin
            v = shadow_deque[pos];
            if (it.opcode == OP_DELETE) shadow_deque.delete(pos);
            step_beats.push_back(make_beat(ST_OK, v, 1'b1));
          end
        end
      end
    endcase
    case (step_beats[0].status)
      ST_FULL:      full_drops++;
      ST_NOT_FOUND: not_found_hits++;
      ST_EMPTY:     empty_hits++;
      default:      ;
    endcase
  endfunction

  // Offers one item and holds it until the block takes it. The beats it is
  // owed are booked at the edge of acceptance, either as worked out by the
  // shadow deque or, for a typed row, as the single beat given in the table.
  task automatic offer_item(in_item_t it, bit typed, status_t st, logic signed [31:0] v);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    deque_step(it);
    if (typed) owed_beats.push_back(make_beat(st, v, 1'b1));
    else foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
  endtask

  // Roughly one item in ten is preceded by a short idle gap on the input.
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every owed beat has come back. At least
  // one edge passes, so in_valid is never lowered and raised in one step.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_beats.size() != 0);
  endtask

  // Random item. Clear is kept rare so the deque can actually reach full, and
  // push_pct steers the fill level. Half of the values come from a tiny pool
  // so searches and deletes hit often, and duplicates appear; the rest are
  // extremes or fully random words that exercise every bit.
  function automatic in_item_t random_item(int push_pct);
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      it.opcode = OP_CLEAR;
    end else if (r < 3 + push_pct) begin
      it.opcode = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else begin
      case ($urandom_range(0, 4))
        0:       it.opcode = OP_POP_FRONT;
        1:       it.opcode = OP_POP_BACK;
        2:       it.opcode = OP_LIST;
        3:       it.opcode = OP_SEARCH;
        default: it.opcode = OP_DELETE;
      endcase
    end
    r = $urandom_range(0, 9);
    if (r < 5)       it.value = $urandom_range(0, 5);
    else if (r == 5) it.value = 32'sh7fff_ffff;
    else if (r == 6) it.value = 32'sh8000_0000;
    else if (r == 7) it.value = -32'sd1;
    else             it.value = $urandom();
    return it;
  endfunction

  task automatic run_random(int count, int push_pct);
    repeat (count) begin
      maybe_gap();
      offer_item(random_item(push_pct), 1'b0, ST_OK, '0);
    end
  endtask

  // Receiver: random stalls on about one cycle in ten, none while quiet, and
  // one long hold-off on request that lets the block back up into its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 10);
      end
    end
  end

  // Result checker and watchdog. Every accepted result beat is matched field
  // by field against the oldest owed beat. The watchdog ends the run if no
  // beat moves on either channel while stuck_cycles climbs to STUCK_LIMIT.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d result beats still owed",
                 $time, stuck_cycles, owed_beats.size());
        $display("simulation failed");
        $finish;
      end else if (out_valid && !out_stall) begin
        beats_checked++;
        if (owed_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: status %0d value %0d last %0d",
                   $time, out_item.status, out_item.result_value, out_item.last);
        end else begin
          want = owed_beats.pop_front();
          if (out_item.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d got %0d",
                     $time, want.status, out_item.status);
          end
          if (out_item.result_value !== want.result_value) begin
            mismatches++;
            $display("%0t: result_value expected %0d got %0d",
                     $time, want.result_value, out_item.result_value);
          end
          if (out_item.last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0d got %0d", $time, want.last, out_item.last);
          end
        end
      end
    end
  end

  // Stimulus: the directed table first, then random phases with different
  // fill pressure, a pause until everything has drained, a stretch without
  // any idling, and a long receiver hold-off while items keep coming.
  initial begin
    in_item_t it;
    int       r;
    int       rep;
    in_valid = 1'b0;
    in_item  = '0;
    rst_n    = 1'b0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      for (rep = 0; rep < DIRECTED[r].reps; rep++) begin
        it.opcode = DIRECTED[r].op;
        it.value  = DIRECTED[r].value + rep;
        maybe_gap();
        offer_item(it, DIRECTED[r].typed, DIRECTED[r].status, DIRECTED[r].result);
      end
    end
    wait_until_drained();

    run_random(110, 45);

    // The sender pauses here until the block has answered everything.
    wait_until_drained();

    quiet = 1'b1;
    run_random(100, 30);
    quiet = 1'b0;

    // The receiver holds off while push-heavy items keep coming, so the block
    // parks a result and then stalls its input for a long time.
    hold_req = 1'b1;
    run_random(30, 50);
    while (hold_req) @(posedge clk);

    // Drive toward full, then drain toward empty.
    run_random(80, 70);
    run_random(70, 20);

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Drove %0d items and checked %0d result beats, %0d mismatching fields.",
             items_sent, beats_checked, mismatches);
    $display("Seen: %0d dropped inserts, %0d misses, %0d empty answers, lists up to %0d.",
             full_drops, not_found_hits, empty_hits, longest_list);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
